// File: rtl/core/rgb5a3_pkg.sv
package rgb5a3_pkg;

  localparam int MaxTiles  = 256;
  localparam int TileCntW  = $clog2(MaxTiles);
  localparam int TileCfgW  = 9;
  localparam int TexelW    = 16;
  localparam int ColorW    = 32;
  localparam int IndexW    = 20;
  localparam int OutDataW  = 56;
  localparam int CfgIndexW = 2;
  localparam int PosW      = TileCntW + 2;
  localparam int WidthPxW  = TileCfgW + 2;

  typedef enum logic [CfgIndexW-1:0] {
    RegTilesAcross = 2'd0,
    RegTilesDown   = 2'd1
  } cfg_reg_t;

  localparam logic [7:0] Widen5 [32] = '{
    8'h00, 8'h08, 8'h10, 8'h18, 8'h20, 8'h29, 8'h31, 8'h39,
    8'h41, 8'h4A, 8'h52, 8'h5A, 8'h62, 8'h6A, 8'h73, 8'h7B,
    8'h83, 8'h8B, 8'h94, 8'h9C, 8'hA4, 8'hAC, 8'hB4, 8'hBD,
    8'hC5, 8'hCD, 8'hD5, 8'hDE, 8'hE6, 8'hEE, 8'hF6, 8'hFF
  };

  localparam logic [7:0] Widen3 [8] = '{
    8'h00, 8'h24, 8'h48, 8'h6D, 8'h91, 8'hB6, 8'hDA, 8'hFF
  };

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  // floor(c * a / 255) for 8-bit operands
  function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] s;
    p = 16'(c) * 16'(a);
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [TileCfgW-1:0] bounded(input logic [TileCfgW-1:0] v);
    if (v == '0) begin
      return TileCfgW'(1);
    end else if (v > TileCfgW'(MaxTiles)) begin
      return TileCfgW'(MaxTiles);
    end
    return v;
  endfunction

endpackage

// File: rtl/core/rgb5a3_tiled_texel_decoder.sv
// channel   direction  payload
// s_axis    in         tdata[15:0] texel_word
// m_axis    out        tdata[31:0] pixel_color, tdata[51:32] pixel_index; tlast last_pixel
// cfg       in         index 0 tiles_across, index 1 tiles_down, data[8:0]
//
// One item per cycle while m_axis does not stall; an accepted item reaches the result register in the next cycle.
// The result register sets the rate: a new item enters whenever it is empty
// or being taken in the same cycle.
// Reset clears position counters and the result valid; tile counts go to 24 by 8.
// A stall on m_axis holds the result and the input side together.
module rgb5a3_tiled_texel_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rgb5a3_pkg::TexelW-1:0]       s_axis_tdata,  // texel_word
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rgb5a3_pkg::OutDataW-1:0]     m_axis_tdata,  // pixel_color, pixel_index, pad
  output logic                                m_axis_tlast,  // last_pixel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgb5a3_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [rgb5a3_pkg::TileCfgW-1:0]     cfg_data
);
  import rgb5a3_pkg::*;

  logic [TileCfgW-1:0] tiles_across;
  logic [TileCfgW-1:0] tiles_down;
  logic [1:0]          column_in_tile;
  logic [1:0]          row_in_tile;
  logic [TileCntW-1:0] tile_column;
  logic [TileCntW-1:0] tile_row;

  logic [TileCfgW-1:0] across;
  logic [TileCfgW-1:0] down;
  logic                end_col;
  logic                end_row;
  logic                last;
  logic                accept;
  logic [TexelW-1:0]   texel;
  logic [7:0]          alpha3;
  logic [7:0]          red;
  logic [7:0]          green;
  logic [7:0]          blue;
  logic [ColorW-1:0]   color;
  logic [PosW-1:0]     row;
  logic [PosW-1:0]     col;
  logic [WidthPxW-1:0] width_px;
  logic [PosW+WidthPxW-1:0] row_base;
  logic [PosW+WidthPxW-1:0] index_full;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign across  = bounded(tiles_across);
  assign down    = bounded(tiles_down);
  assign end_col = ({1'b0, tile_column} + TileCfgW'(1)) >= across;
  assign end_row = ({1'b0, tile_row} + TileCfgW'(1)) >= down;
  assign last    = (column_in_tile == 2'd3) && (row_in_tile == 2'd3) && end_col && end_row;

  assign texel  = {s_axis_tdata[7:0], s_axis_tdata[15:8]};
  assign alpha3 = Widen3[texel[14:12]];

  always_comb begin
    if (texel[15]) begin
      red   = Widen5[texel[14:10]];
      green = Widen5[texel[9:5]];
      blue  = Widen5[texel[4:0]];
    end else begin
      red   = blend(widen4(texel[11:8]), alpha3);
      green = blend(widen4(texel[7:4]), alpha3);
      blue  = blend(widen4(texel[3:0]), alpha3);
    end
  end

  assign color = {8'hFF, red, green, blue};

  assign row        = {tile_row, row_in_tile};
  assign col        = {tile_column, column_in_tile};
  assign width_px   = {across, 2'b00};
  assign row_base   = (PosW+WidthPxW)'(row) * (PosW+WidthPxW)'(width_px);
  assign index_full = row_base + (PosW+WidthPxW)'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_across <= TileCfgW'(24);
      tiles_down   <= TileCfgW'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegTilesAcross: tiles_across <= cfg_data;
        RegTilesDown:   tiles_down   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_in_tile <= '0;
      row_in_tile    <= '0;
      tile_column    <= '0;
      tile_row       <= '0;
    end else if (accept) begin
      column_in_tile <= column_in_tile + 2'd1;
      if (column_in_tile == 2'd3) begin
        row_in_tile <= row_in_tile + 2'd1;
        if (row_in_tile == 2'd3) begin
          if (!end_col) begin
            tile_column <= tile_column + TileCntW'(1);
          end else begin
            tile_column <= '0;
            tile_row    <= end_row ? '0 : tile_row + TileCntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {(OutDataW-ColorW-IndexW)'(0), index_full[IndexW-1:0], color};
      m_axis_tlast <= last;
    end
  end

endmodule

// File: rtl/core/rgb5a3_checker.sv
module rgb5a3_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rgb5a3_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import rgb5a3_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed under stall");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  a_opaque_alpha: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[ColorW-1:ColorW-8] == 8'hFF)
    else $error("alpha not opaque");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind rgb5a3_tiled_texel_decoder rgb5a3_checker u_rgb5a3_checker (.*);
